[sv/pxp_pkg.sv]
// pxp_pkg: shared types and constants for the pixel to display format packer
// no dependencies

package pxp_pkg;

    localparam int PIXEL_W   = 24;
    localparam int BYTE_W    = 8;
    localparam int CFG_IDX_W = 2;
    localparam int Q_DEPTH   = 4;
    localparam int Q_PTR_W   = 2;
    localparam int Q_CNT_W   = 3;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_PIXEL_FORMAT   = 2'd0,
        REG_PICTURE_WIDTH  = 2'd1,
        REG_PICTURE_HEIGHT = 2'd2,
        REG_UNUSED         = 2'd3
    } reg_index_t;

    typedef enum logic [2:0] {
        FMT_MONO_BLACK = 3'd0,
        FMT_MONO_SET   = 3'd1,
        FMT_MONO_PACK  = 3'd2,
        FMT_CODE4      = 3'd3,
        FMT_RGB565     = 3'd4,
        FMT_BAD5       = 3'd5,
        FMT_BAD6       = 3'd6,
        FMT_BAD7       = 3'd7
    } pixel_format_t;

    // one queue entry: the words caused by one pixel
    typedef struct packed {
        logic              two_words;
        logic [BYTE_W-1:0] byte0;
        logic [BYTE_W-1:0] byte1;
        logic              done;
        logic              status;
    } job_t;

    typedef struct packed {
        logic push;
        logic pop;
        logic full;
        logic empty;
    } q_ctrl_t;

endpackage

[sv/pxp_front.sv]
// pxp_front: config registers, raster counters and byte accumulator
// classifies each pixel and emits one job per pixel that yields words; uses pxp_pkg

module pxp_front #(
    parameter int DIM_BITS = 12
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            cfg_wr_en,
    input  logic [pxp_pkg::CFG_IDX_W-1:0]   cfg_addr,
    input  logic [DIM_BITS-1:0]             cfg_wdata,
    input  logic                            pix_valid,
    output logic                            pix_ready,
    input  logic [pxp_pkg::PIXEL_W-1:0]     pix_rgb,
    input  logic                            q_full,
    output logic                            q_push,
    output pxp_pkg::job_t                   q_job
);

    pxp_pkg::pixel_format_t       fmt_reg;
    logic [DIM_BITS-1:0]          width_reg;
    logic [DIM_BITS-1:0]          height_reg;
    logic [pxp_pkg::BYTE_W-1:0]   acc_reg, acc_next;
    logic [2:0]                   bitpos_reg, bitpos_next;
    logic [DIM_BITS-1:0]          col_reg, col_next;
    logic [DIM_BITS-1:0]          row_reg, row_next;

    logic                         last_col;
    logic                         last_pic;
    logic                         pix_zero;
    logic                         set_bit;
    logic [pxp_pkg::BYTE_W-1:0]   acc_or;
    logic [2:0]                   bitpos_inc;
    logic [2:0]                   code;
    logic                         emit;
    pxp_pkg::job_t                job;
    logic                         accept;
    logic                         cfg_hit;

    assign pix_ready = !q_full;
    assign accept    = pix_valid && !q_full;
    assign cfg_hit   = cfg_wr_en && (cfg_addr != pxp_pkg::REG_UNUSED);

    assign last_col = (col_reg == (width_reg - DIM_BITS'(1)));
    assign last_pic = last_col && (row_reg == (height_reg - DIM_BITS'(1)));
    assign pix_zero = (pix_rgb == '0);
    assign code     = {(pix_rgb[23:16] != '0), (pix_rgb[15:8] != '0), (pix_rgb[7:0] != '0)};

    always_comb
    begin
        set_bit     = (fmt_reg == pxp_pkg::FMT_MONO_BLACK) ? pix_zero : !pix_zero;
        bitpos_inc  = bitpos_reg + 3'd1;
        acc_or      = acc_reg;
        acc_next    = '0;
        bitpos_next = '0;
        emit        = 1'b1;
        job         = '0;
        job.done    = last_pic;
        unique case (fmt_reg)
            pxp_pkg::FMT_MONO_BLACK, pxp_pkg::FMT_MONO_SET, pxp_pkg::FMT_MONO_PACK:
            begin
                if (set_bit)
                begin
                    acc_or = acc_reg | (8'h80 >> bitpos_reg);
                end
                emit = (bitpos_inc == 3'd0) || last_pic
                       || (last_col && (fmt_reg != pxp_pkg::FMT_MONO_PACK));
                if (!emit)
                begin
                    acc_next    = acc_or;
                    bitpos_next = bitpos_inc;
                end
                job.byte0 = acc_or;
            end
            pxp_pkg::FMT_CODE4:
            begin
                acc_or = acc_reg | (bitpos_reg[2] ? {1'b0, code, 4'h0} : {5'h00, code});
                emit   = bitpos_reg[2] || last_pic;
                if (!emit)
                begin
                    acc_next    = acc_or;
                    bitpos_next = 3'd4;
                end
                job.byte0 = acc_or;
            end
            pxp_pkg::FMT_RGB565:
            begin
                job.two_words = 1'b1;
                job.byte0     = {pix_rgb[23:19], pix_rgb[15:13]};
                job.byte1     = {pix_rgb[12:10], pix_rgb[7:3]};
            end
            default:
            begin
                job.status = 1'b1;
                job.done   = 1'b0;
            end
        endcase

        if (last_col)
        begin
            col_next = '0;
            row_next = last_pic ? '0 : row_reg + DIM_BITS'(1);
        end
        else
        begin
            col_next = col_reg + DIM_BITS'(1);
            row_next = row_reg;
        end
    end

    assign q_push = accept && emit;
    assign q_job  = job;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fmt_reg    <= pxp_pkg::FMT_MONO_BLACK;
            width_reg  <= DIM_BITS'(128);
            height_reg <= DIM_BITS'(64);
            acc_reg    <= '0;
            bitpos_reg <= '0;
            col_reg    <= '0;
            row_reg    <= '0;
        end
        else if (cfg_hit)
        begin
            unique case (cfg_addr)
                pxp_pkg::REG_PIXEL_FORMAT:   fmt_reg    <= pxp_pkg::pixel_format_t'(cfg_wdata[2:0]);
                pxp_pkg::REG_PICTURE_WIDTH:  width_reg  <= cfg_wdata;
                pxp_pkg::REG_PICTURE_HEIGHT: height_reg <= cfg_wdata;
                default:                     fmt_reg    <= fmt_reg;
            endcase
            acc_reg    <= '0;
            bitpos_reg <= '0;
            col_reg    <= '0;
            row_reg    <= '0;
        end
        else if (accept)
        begin
            acc_reg    <= acc_next;
            bitpos_reg <= bitpos_next;
            col_reg    <= col_next;
            row_reg    <= row_next;
        end
    end

endmodule

[sv/pxp_queue.sv]
// pxp_queue: short job queue between front and back
// register based, one push and one pop per cycle; uses pxp_pkg

module pxp_queue (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              push,
    input  pxp_pkg::job_t     push_job,
    input  logic              pop,
    output pxp_pkg::job_t     head_job,
    output pxp_pkg::q_ctrl_t  ctrl
);

    pxp_pkg::job_t                 entry_reg [pxp_pkg::Q_DEPTH];
    logic [pxp_pkg::Q_PTR_W-1:0]   wr_ptr_reg;
    logic [pxp_pkg::Q_PTR_W-1:0]   rd_ptr_reg;
    logic [pxp_pkg::Q_CNT_W-1:0]   count_reg, count_next;

    assign ctrl.push  = push;
    assign ctrl.pop   = pop;
    assign ctrl.full  = (count_reg == pxp_pkg::Q_CNT_W'(pxp_pkg::Q_DEPTH));
    assign ctrl.empty = (count_reg == '0);
    assign head_job   = entry_reg[rd_ptr_reg];

    always_comb
    begin
        count_next = count_reg;
        if (push && !pop)
        begin
            count_next = count_reg + pxp_pkg::Q_CNT_W'(1);
        end
        else if (pop && !push)
        begin
            count_next = count_reg - pxp_pkg::Q_CNT_W'(1);
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entry_reg[wr_ptr_reg] <= push_job;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= wr_ptr_reg + pxp_pkg::Q_PTR_W'(1);
            end
            if (pop)
            begin
                rd_ptr_reg <= rd_ptr_reg + pxp_pkg::Q_PTR_W'(1);
            end
            count_reg <= count_next;
        end
    end

    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        push |-> !ctrl.full)
        else $error("queue push while full");

    a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
        pop |-> !ctrl.empty)
        else $error("queue pop while empty");

    a_ptr_count: assert property (@(posedge clk) disable iff (!rst_n)
        (wr_ptr_reg - rd_ptr_reg) == count_reg[pxp_pkg::Q_PTR_W-1:0])
        else $error("queue pointers disagree with count");

endmodule

[sv/pxp_back.sv]
// pxp_back: output register that turns jobs into output words
// rgb565 jobs give two output words, all others one; uses pxp_pkg

module pxp_back (
    input  logic                         clk,
    input  logic                         rst_n,
    input  pxp_pkg::job_t                head_job,
    input  logic                         q_empty,
    output logic                         q_pop,
    output logic                         m_tvalid,
    input  logic                         m_tready,
    output logic [pxp_pkg::BYTE_W-1:0]   m_tdata,
    output logic                         m_tlast,
    output logic                         m_tuser
);

    pxp_pkg::job_t  job_reg;
    logic           valid_reg;
    logic           phase_reg;
    logic           last_word;
    logic           out_done;

    assign last_word = !job_reg.two_words || phase_reg;
    assign q_pop     = !q_empty && (!valid_reg || (m_tready && last_word));
    assign out_done  = job_reg.done && last_word;

    assign m_tvalid = valid_reg;
    assign m_tdata  = phase_reg ? job_reg.byte1 : job_reg.byte0;
    assign m_tlast  = out_done;
    assign m_tuser  = job_reg.status;

    always_ff @(posedge clk)
    begin
        if (q_pop)
        begin
            job_reg <= head_job;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
            phase_reg <= 1'b0;
        end
        else if (q_pop)
        begin
            valid_reg <= 1'b1;
            phase_reg <= 1'b0;
        end
        else if (valid_reg && m_tready)
        begin
            valid_reg <= !last_word;
            phase_reg <= !last_word;
        end
    end

    a_error_word_clean: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && m_tuser) |-> (m_tdata == '0 && !m_tlast))
        else $error("error word carries data");

    a_second_word_after_first: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && m_tready && job_reg.two_words && !phase_reg) |=> (m_tvalid && phase_reg))
        else $error("second rgb565 word missing");

endmodule

[sv/pixel_to_display_format_packer.sv]
// pixel_to_display_format_packer: top level, 24-bit rgb pixels in, packed display bytes out
// a completed word is registered in a queue entry, then in the output register
// throughput: one pixel per cycle while the queue has room; rgb565 paced by the word port
// a four-entry job queue lets input and output stall independently
// reset: asynchronous, active low; format 0, width 128, height 64, counters and queue clear
// depends on pxp_pkg, pxp_front, pxp_queue, pxp_back

module pixel_to_display_format_packer #(
    parameter int DIM_BITS = 12
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            cfg_wr_en,
    input  logic [pxp_pkg::CFG_IDX_W-1:0]   cfg_addr,
    input  logic [DIM_BITS-1:0]             cfg_wdata,
    input  logic                            s_tvalid,
    output logic                            s_tready,
    input  logic [pxp_pkg::PIXEL_W-1:0]     s_tdata,   // pixel_rgb
    output logic                            m_tvalid,
    input  logic                            m_tready,
    output logic [pxp_pkg::BYTE_W-1:0]      m_tdata,   // out_byte
    output logic                            m_tlast,   // picture_done
    output logic                            m_tuser    // status
);

    pxp_pkg::job_t     push_job;
    pxp_pkg::job_t     head_job;
    pxp_pkg::q_ctrl_t  q_ctrl;
    logic              q_push;
    logic              q_pop;

    pxp_front #(
        .DIM_BITS (DIM_BITS)
    ) u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_wr_en (cfg_wr_en),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata),
        .pix_valid (s_tvalid),
        .pix_ready (s_tready),
        .pix_rgb   (s_tdata),
        .q_full    (q_ctrl.full),
        .q_push    (q_push),
        .q_job     (push_job)
    );

    pxp_queue u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (q_push),
        .push_job (push_job),
        .pop      (q_pop),
        .head_job (head_job),
        .ctrl     (q_ctrl)
    );

    pxp_back u_back (
        .clk      (clk),
        .rst_n    (rst_n),
        .head_job (head_job),
        .q_empty  (q_ctrl.empty),
        .q_pop    (q_pop),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast),
        .m_tuser  (m_tuser)
    );

endmodule
